// File: rtl/core/sfs_pkg.sv
// sfs_pkg: shared types and constants of the sprite frame sequencer.
// No dependencies; used by every module under rtl/core.
package sfs_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int TIME_W     = 32;
  localparam int POS_W      = $clog2(MAX_FRAMES);
  localparam int FRAME_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int MODE_W     = 2;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_START  = 2'd2,
    FUNC_REWIND = 2'd3
  } func_t;

  localparam logic [MODE_W-1:0] MODE_ONCE      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOP      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OSCILLATE = 2'd2;

  // register select is paddr[2]; low bits are the byte offset
  localparam logic REG_FRAME_COUNT   = 1'b0;
  localparam logic REG_PLAYBACK_MODE = 1'b1;

  typedef struct packed {
    func_t               func;
    logic [TIME_W-1:0]   delta;
    logic [FRAME_W-1:0]  frame_index;
    logic [TIME_W-1:0]   frame_duration;
  } cmd_word_t;

  typedef struct packed {
    logic [FRAME_W-1:0] current_frame;
    logic               playing;
    logic               frame_changed;
  } rsp_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] frame_count;
    logic [MODE_W-1:0]  playback_mode;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  addr;
    logic [TIME_W-1:0] data;
  } mem_wr_t;

endpackage

// File: rtl/core/sfs_cfg_regs.sv
// sfs_cfg_regs: APB-style register file holding frame_count and playback_mode.
// Depends on sfs_pkg.
module sfs_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfs_pkg::APB_AW-1:0] paddr,
  input  logic [sfs_pkg::APB_DW-1:0] pwdata,
  output logic [sfs_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output sfs_pkg::cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_count   <= sfs_pkg::COUNT_W'(1);
      cfg.playback_mode <= sfs_pkg::MODE_ONCE;
    end else if (wr_en) begin
      case (paddr[2])
        sfs_pkg::REG_FRAME_COUNT: begin
          cfg.frame_count <= pwdata[sfs_pkg::COUNT_W-1:0];
        end
        sfs_pkg::REG_PLAYBACK_MODE: begin
          cfg.playback_mode <= pwdata[sfs_pkg::MODE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      sfs_pkg::REG_FRAME_COUNT: begin
        prdata[sfs_pkg::COUNT_W-1:0] = cfg.frame_count;
      end
      sfs_pkg::REG_PLAYBACK_MODE: begin
        prdata[sfs_pkg::MODE_W-1:0] = cfg.playback_mode;
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/sfs_dur_mem.sv
// sfs_dur_mem: frame duration memory, one write and one registered read port.
// A read that meets a write to the same entry returns the new data. Depends on sfs_pkg.
module sfs_dur_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  sfs_pkg::mem_wr_t            wr,
  input  logic                        rd_en,
  input  logic [sfs_pkg::POS_W-1:0]   rd_addr,
  output logic [sfs_pkg::TIME_W-1:0]  rd_data
);

  logic [sfs_pkg::TIME_W-1:0] mem [sfs_pkg::MAX_FRAMES];
  logic [sfs_pkg::TIME_W-1:0] rd_q;
  logic [sfs_pkg::TIME_W-1:0] fwd_data;
  logic                       fwd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr.en && (wr.addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

  a_fwd_new_data: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr.en && (wr.addr == rd_addr) |=> rd_data == $past(wr.data))
    else $error("read colliding with a write did not return the written data");

endmodule

// File: rtl/core/sfs_exec.sv
// sfs_exec: sequencer state (position, elapsed time, direction, running) and
// the per-word update. Depends on sfs_pkg.
module sfs_exec (
  input  logic                        clk,
  input  logic                        rst,
  input  sfs_pkg::cfg_t               cfg,
  input  logic                        fire,
  input  sfs_pkg::cmd_word_t          item,
  input  logic [sfs_pkg::TIME_W-1:0]  dur,
  output logic [sfs_pkg::POS_W-1:0]   pos,
  output logic [sfs_pkg::POS_W-1:0]   pos_next,
  output sfs_pkg::rsp_word_t          result,
  output sfs_pkg::mem_wr_t            mem_wr
);

  localparam int TW = sfs_pkg::TIME_W;
  localparam int PW = sfs_pkg::POS_W;

  logic [TW-1:0] elapsed;
  logic          backward;
  logic          running;

  logic [TW-1:0] elapsed_next;
  logic          backward_next;
  logic          running_next;

  logic [TW:0]   rem;
  logic [TW+1:0] sum;
  logic          sum_pos;
  logic [TW-1:0] sum_sat;
  logic [TW-1:0] grow;

  logic [PW-1:0] last;
  logic [PW-1:0] p;
  logic [PW-1:0] adv_pos;
  logic          adv_backward;
  logic          adv_running;

  // elapsed - dur, then + delta; positive sum means the frame ran out
  assign rem     = {1'b0, elapsed} - {1'b0, dur};
  assign sum     = {2'b00, item.delta} + {rem[TW], rem};
  assign sum_pos = !sum[TW+1] && (sum != '0);
  assign sum_sat = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  assign grow    = elapsed + item.delta;

  always_comb begin
    if (cfg.frame_count == '0) begin
      last = '0;
    end else if (int'(cfg.frame_count) > sfs_pkg::MAX_FRAMES) begin
      last = PW'(sfs_pkg::MAX_FRAMES - 1);
    end else begin
      last = PW'(cfg.frame_count - sfs_pkg::COUNT_W'(1));
    end
  end

  assign p = (pos > last) ? last : pos;

  always_comb begin
    adv_pos      = p;
    adv_backward = backward;
    adv_running  = running;
    case (cfg.playback_mode)
      sfs_pkg::MODE_ONCE: begin
        if (!backward) begin
          if (p < last) adv_pos = p + PW'(1);
          else          adv_running = 1'b0;
        end else begin
          if (p != '0)  adv_pos = p - PW'(1);
          else          adv_running = 1'b0;
        end
      end
      sfs_pkg::MODE_LOOP: begin
        if (!backward) adv_pos = (p >= last) ? '0 : p + PW'(1);
        else           adv_pos = (p == '0) ? last : p - PW'(1);
      end
      sfs_pkg::MODE_OSCILLATE: begin
        if (!backward) adv_pos = (p < last) ? p + PW'(1) : p;
        else           adv_pos = (p != '0) ? p - PW'(1) : p;
        if ((adv_pos == '0) || (adv_pos == last)) adv_backward = !backward;
      end
      default: begin
        // unused mode: time is still carried, frame stays put
        adv_pos = pos;
      end
    endcase
  end

  always_comb begin
    pos_next      = pos;
    elapsed_next  = elapsed;
    backward_next = backward;
    running_next  = running;
    case (item.func)
      sfs_pkg::FUNC_TICK: begin
        if (running) begin
          if (sum_pos) begin
            elapsed_next  = sum_sat;
            pos_next      = adv_pos;
            backward_next = adv_backward;
            running_next  = adv_running;
          end else begin
            elapsed_next = grow;
          end
        end
      end
      sfs_pkg::FUNC_START: begin
        running_next = 1'b1;
      end
      sfs_pkg::FUNC_REWIND: begin
        elapsed_next = '0;
        pos_next     = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      elapsed  <= '0;
      backward <= 1'b0;
      running  <= 1'b0;
    end else if (fire) begin
      pos      <= pos_next;
      elapsed  <= elapsed_next;
      backward <= backward_next;
      running  <= running_next;
    end
  end

  assign result.current_frame = sfs_pkg::FRAME_W'(pos_next);
  assign result.playing       = running_next;
  assign result.frame_changed = (item.func == sfs_pkg::FUNC_TICK) && (pos_next != pos);

  assign mem_wr.en   = fire && (item.func == sfs_pkg::FUNC_LOAD) &&
                       (int'(item.frame_index) < sfs_pkg::MAX_FRAMES);
  assign mem_wr.addr = PW'(item.frame_index);
  assign mem_wr.data = item.frame_duration;

  a_stopped_tick_idle: assert property (@(posedge clk) disable iff (rst)
    fire && (item.func == sfs_pkg::FUNC_TICK) && !running
    |=> $stable(pos) && $stable(elapsed) && !running)
    else $error("tick while stopped changed the sequencer state");

  a_rewind_clears: assert property (@(posedge clk) disable iff (rst)
    fire && (item.func == sfs_pkg::FUNC_REWIND) |=> (pos == '0) && (elapsed == '0))
    else $error("rewind did not clear position and elapsed time");

  a_changed_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    result.frame_changed |-> (item.func == sfs_pkg::FUNC_TICK) && running)
    else $error("frame change flagged outside a running tick");

endmodule

// File: rtl/core/sprite_frame_sequencer.sv
// sprite_frame_sequencer: top level; command/response channels, execute stage,
// response register. Depends on sfs_pkg, sfs_cfg_regs, sfs_dur_mem, sfs_exec.
//
// The sequencer takes one command word per clock while cmd_stall is low and
// returns one response word per command, in order. An accepted word reads the
// frame duration memory in the cycle it is accepted, then waits in the execute
// stage until that stage fires, and its response is presented from the response
// register. Throughput is one word per cycle while nothing stalls, with no
// bubbles after frame changes or duration loads. The duration read address is
// the frame position left by the word ahead of it, resolved in the same cycle,
// and a load to the entry being read is forwarded. cmd_stall rises only while
// the execute stage holds a word that cannot move into a full, stalled response
// register. Durations never loaded read as arbitrary values. frame_count and
// playback_mode are to be written only while no command is in flight.
module sprite_frame_sequencer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  sfs_pkg::cmd_word_t         cmd,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output sfs_pkg::rsp_word_t         rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfs_pkg::APB_AW-1:0] paddr,
  input  logic [sfs_pkg::APB_DW-1:0] pwdata,
  output logic [sfs_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  sfs_pkg::cfg_t                cfg;
  sfs_pkg::cmd_word_t           ex_item;
  logic                         ex_valid;
  logic                         ex_fire;
  logic                         accept;
  logic [sfs_pkg::TIME_W-1:0]   dur;
  logic [sfs_pkg::POS_W-1:0]    pos;
  logic [sfs_pkg::POS_W-1:0]    pos_next;
  logic [sfs_pkg::POS_W-1:0]    rd_addr;
  sfs_pkg::rsp_word_t           result;
  sfs_pkg::mem_wr_t             mem_wr;

  assign ex_fire   = ex_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = ex_valid && !ex_fire;
  assign accept    = cmd_valid && !cmd_stall;
  // read where the word ahead leaves the position
  assign rd_addr   = ex_fire ? pos_next : pos;

  sfs_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfs_dur_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (mem_wr),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (dur)
  );

  sfs_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fire     (ex_fire),
    .item     (ex_item),
    .dur      (dur),
    .pos      (pos),
    .pos_next (pos_next),
    .result   (result),
    .mem_wr   (mem_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (accept) begin
      ex_valid <= 1'b1;
    end else if (ex_fire) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_item <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ex_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      rsp <= result;
    end
  end

  a_fire_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    ex_fire |=> rsp_valid && (rsp == $past(result)))
    else $error("executed word did not reach the response register");

  a_held_word_kept: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |=> ex_valid && $stable(ex_item))
    else $error("stalled execute stage lost or changed its word");

endmodule
